@@ hdl/fba_pkg.sv @@
// Shared types and codes of the flow byte accounting block.
package fba_pkg;

  localparam int ENTRY_IDX_W = 6;
  localparam int SLOT_W      = 5;
  localparam int COUNT_W     = 64;

  typedef enum logic [1:0] {
    REQ_PACKET   = 2'd0,
    REQ_ENTRY_WR = 2'd1,
    REQ_READ     = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_e;

  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  localparam logic PROTO_TCP = 1'b0;
  localparam logic PROTO_UDP = 1'b1;

  localparam logic [1:0] MATCH_NONE = 2'd0;
  localparam logic [1:0] MATCH_SENT = 2'd1;
  localparam logic [1:0] MATCH_RECV = 2'd2;

  typedef struct packed {
    req_e                   req_type;
    logic                   protocol;
    logic [1:0]             family;
    logic [31:0]            src_ip;
    logic [15:0]            src_port;
    logic [31:0]            dst_ip;
    logic [15:0]            dst_port;
    logic [15:0]            packet_len;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   entry_valid;
    logic [SLOT_W-1:0]      slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         match_kind;
    logic [SLOT_W-1:0]  matched_slot;
    logic [COUNT_W-1:0] sent_bytes;
    logic [COUNT_W-1:0] received_bytes;
    logic               family_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_CNT_RD,
    ST_CNT_WR
  } state_e;

  typedef struct packed {
    logic sweep;
    logic load;
    logic scan;
    logic ent_wr;
    logic cnt_rd;
    logic cnt_wr;
    logic emit_plain;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    req_e req_type;
    logic is_ipv4;
    logic scan_done;
    logic hit;
  } ctrl_sts_t;

endpackage

@@ hdl/fba_datapath.sv @@
// Datapath: flow table memories, table scan, counter memories and result register.
module fba_datapath #(
  parameter int FLOW_ENTRIES = 64,
  parameter int OWNER_SLOTS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fba_pkg::in_item_t item_i,
  input  fba_pkg::ctrl_cmd_t cmd_i,
  output fba_pkg::ctrl_sts_t sts_o,
  output fba_pkg::out_item_t result_o,
  output logic              result_valid_o
);
  import fba_pkg::*;

  localparam int AW        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int SW        = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam int SCW       = $clog2(FLOW_ENTRIES + 1);
  localparam int SWEEP_LEN = (FLOW_ENTRIES > OWNER_SLOTS) ? FLOW_ENTRIES : OWNER_SLOTS;
  localparam int SWW       = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;
  localparam int EXW       = (AW > ENTRY_IDX_W) ? AW : ENTRY_IDX_W;
  localparam int SXW       = (SW > SLOT_W) ? SW : SLOT_W;

  typedef struct packed {
    logic              valid;
    logic [31:0]       ip;
    logic [15:0]       port;
    logic [SLOT_W-1:0] slot;
  } flow_entry_t;

  flow_entry_t        tcp_mem [FLOW_ENTRIES];
  flow_entry_t        udp_mem [FLOW_ENTRIES];
  logic [COUNT_W-1:0] sent_mem [OWNER_SLOTS];
  logic [COUNT_W-1:0] recv_mem [OWNER_SLOTS];

  in_item_t           req_q;
  logic [SCW-1:0]     scan_q, scan_d;
  logic               rd_vld_q;
  logic               src_hit_q, dst_hit_q;
  logic [SLOT_W-1:0]  src_slot_q, dst_slot_q;
  flow_entry_t        tcp_rd_q, udp_rd_q;
  logic [SWW-1:0]     sweep_q, sweep_d;
  logic [SW-1:0]      cslot_q;
  logic               cslot_ok_q;
  logic [SLOT_W-1:0]  mslot_q;
  logic [COUNT_W-1:0] sent_rd_q, recv_rd_q;
  out_item_t          result_q, result_d;
  logic               result_valid_q;

  function automatic logic [ENTRY_IDX_W-1:0] item_sel_entry(input logic [ENTRY_IDX_W-1:0] e);
    return e;
  endfunction

  // Table scan: one entry is read per cycle and compared in the next.
  logic        scan_more, issue;
  logic [AW-1:0] scan_addr;
  flow_entry_t tab_rd;
  logic        src_m, dst_m;

  assign scan_more = 32'(scan_q) < 32'(FLOW_ENTRIES);
  assign issue     = cmd_i.scan && scan_more;
  assign scan_addr = scan_q[AW-1:0];
  assign scan_d    = scan_q + SCW'(issue);
  assign tab_rd    = (req_q.protocol == PROTO_UDP) ? udp_rd_q : tcp_rd_q;
  assign src_m     = rd_vld_q && tab_rd.valid && (tab_rd.ip == req_q.src_ip)
                     && (tab_rd.port == req_q.src_port);
  assign dst_m     = rd_vld_q && tab_rd.valid && (tab_rd.ip == req_q.dst_ip)
                     && (tab_rd.port == req_q.dst_port);

  // Flow table write port, shared by the reset sweep and entry writes.
  logic              sweep_tab;
  logic [EXW-1:0]    eidx_ext;
  logic              ent_ok;
  logic              tcp_we, udp_we;
  logic [AW-1:0]     tab_waddr;
  flow_entry_t       tab_wdata;

  assign sweep_tab = cmd_i.sweep && (32'(sweep_q) < 32'(FLOW_ENTRIES));
  assign eidx_ext  = EXW'(item_sel_entry(req_q.entry_index));
  assign ent_ok    = (32'(req_q.entry_index) < 32'(FLOW_ENTRIES))
                     && (32'(req_q.slot_index) < 32'(OWNER_SLOTS));

  always_comb begin
    tab_waddr = eidx_ext[AW-1:0];
    tab_wdata = '{valid: req_q.entry_valid, ip: req_q.src_ip, port: req_q.src_port,
                  slot: req_q.slot_index};
    tcp_we    = 1'b0;
    udp_we    = 1'b0;
    if (sweep_tab) begin
      tab_waddr = sweep_q[AW-1:0];
      tab_wdata = '0;
      tcp_we    = 1'b1;
      udp_we    = 1'b1;
    end else if (cmd_i.ent_wr && ent_ok) begin
      tcp_we = (req_q.protocol == PROTO_TCP);
      udp_we = (req_q.protocol == PROTO_UDP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tcp_we) begin
      tcp_mem[tab_waddr] <= tab_wdata;
    end
    tcp_rd_q <= tcp_mem[scan_addr];
  end

  always_ff @(posedge clk_i) begin
    if (udp_we) begin
      udp_mem[tab_waddr] <= tab_wdata;
    end
    udp_rd_q <= udp_mem[scan_addr];
  end

  // Counter stage: read the chosen slot, then write back and form the result.
  logic [SLOT_W-1:0]  sel_slot;
  logic [SXW-1:0]     sel_ext;
  logic [SW-1:0]      cnt_raddr;
  logic               sel_ok;
  logic [COUNT_W-1:0] sent_new, recv_new;
  logic               cnt_we;
  logic [SW-1:0]      cnt_waddr;
  logic [COUNT_W-1:0] sent_wdata, recv_wdata;
  logic               is_packet;

  assign is_packet = (req_q.req_type == REQ_PACKET);
  assign sel_slot  = !is_packet ? req_q.slot_index
                     : (src_hit_q ? src_slot_q : dst_slot_q);
  assign sel_ext   = SXW'(sel_slot);
  assign cnt_raddr = sel_ext[SW-1:0];
  assign sel_ok    = 32'(sel_slot) < 32'(OWNER_SLOTS);

  always_comb begin
    sent_new = sent_rd_q;
    recv_new = recv_rd_q;
    unique case (req_q.req_type)
      REQ_PACKET: begin
        if (src_hit_q) begin
          sent_new = sent_rd_q + COUNT_W'(req_q.packet_len);
        end else begin
          recv_new = recv_rd_q + COUNT_W'(req_q.packet_len);
        end
      end
      REQ_CLEAR: begin
        sent_new = '0;
        recv_new = '0;
      end
      REQ_ENTRY_WR, REQ_READ: begin
        sent_new = sent_rd_q;
        recv_new = recv_rd_q;
      end
    endcase
  end

  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = cslot_q;
    sent_wdata = sent_new;
    recv_wdata = recv_new;
    if (cmd_i.sweep) begin
      cnt_we     = 32'(sweep_q) < 32'(OWNER_SLOTS);
      cnt_waddr  = sweep_q[SW-1:0];
      sent_wdata = '0;
      recv_wdata = '0;
    end else if (cmd_i.cnt_wr) begin
      cnt_we = cslot_ok_q && (is_packet || (req_q.req_type == REQ_CLEAR));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      sent_mem[cnt_waddr] <= sent_wdata;
      recv_mem[cnt_waddr] <= recv_wdata;
    end
    sent_rd_q <= sent_mem[cnt_raddr];
    recv_rd_q <= recv_mem[cnt_raddr];
  end

  // Result formation.
  always_comb begin
    result_d = '0;
    if (cmd_i.cnt_wr) begin
      if (is_packet) begin
        result_d.match_kind = src_hit_q ? MATCH_SENT : MATCH_RECV;
      end else begin
        result_d.match_kind = MATCH_NONE;
      end
      result_d.matched_slot = mslot_q;
      if (cslot_ok_q) begin
        result_d.sent_bytes     = sent_new;
        result_d.received_bytes = recv_new;
      end
    end else begin
      result_d.family_error = is_packet && (req_q.family != FAM_IPV4)
                              && (req_q.family != FAM_IPV6);
    end
  end

  assign sweep_d = sweep_q + SWW'(1);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q         <= '0;
      rd_vld_q       <= 1'b0;
      src_hit_q      <= 1'b0;
      dst_hit_q      <= 1'b0;
      sweep_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.emit_plain || cmd_i.cnt_wr;
      if (cmd_i.sweep) begin
        sweep_q <= sweep_d;
      end
      if (cmd_i.load) begin
        scan_q    <= '0;
        rd_vld_q  <= 1'b0;
        src_hit_q <= 1'b0;
        dst_hit_q <= 1'b0;
      end else begin
        scan_q   <= scan_d;
        rd_vld_q <= issue;
        if (src_m) begin
          src_hit_q <= 1'b1;
        end
        if (dst_m) begin
          dst_hit_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers. Only the first matching entry of each search is kept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= item_i;
    end
    if (src_m && !src_hit_q) begin
      src_slot_q <= tab_rd.slot;
    end
    if (dst_m && !dst_hit_q) begin
      dst_slot_q <= tab_rd.slot;
    end
    if (cmd_i.cnt_rd) begin
      cslot_q    <= cnt_raddr;
      cslot_ok_q <= sel_ok;
      mslot_q    <= sel_slot;
    end
    if (cmd_i.emit_plain || cmd_i.cnt_wr) begin
      result_q <= result_d;
    end
  end

  assign sts_o.sweep_last = (sweep_q == SWW'(SWEEP_LEN - 1));
  assign sts_o.req_type   = req_q.req_type;
  assign sts_o.is_ipv4    = (req_q.family == FAM_IPV4);
  assign sts_o.scan_done  = src_hit_q || (!scan_more && !rd_vld_q);
  assign sts_o.hit        = src_hit_q || dst_hit_q;

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

`ifndef SYNTHESIS
  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("two results in consecutive cycles");
  a_read_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(issue))
    else $error("table data marked valid without a read");
  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_wr |-> $past(cmd_i.cnt_rd))
    else $error("counter write-back without a preceding read");
`endif

endmodule

@@ hdl/fba_ctrl.sv @@
// Controller state machine sequencing the reset sweep, table scan and counter update.
module fba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  fba_pkg::ctrl_sts_t  sts_i,
  output fba_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy
);
  import fba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.req_type)
          REQ_PACKET:         state_d = sts_i.is_ipv4 ? ST_SCAN : ST_IDLE;
          REQ_ENTRY_WR:       state_d = ST_IDLE;
          REQ_READ, REQ_CLEAR: state_d = ST_CNT_RD;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.hit ? ST_CNT_RD : ST_IDLE;
        end
      end
      ST_CNT_RD: state_d = ST_CNT_WR;
      ST_CNT_WR: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_INIT:  cmd_o.sweep = 1'b1;
      ST_IDLE:  cmd_o.load  = start;
      ST_DISPATCH: begin
        unique case (sts_i.req_type)
          REQ_PACKET:   cmd_o.emit_plain = !sts_i.is_ipv4;
          REQ_ENTRY_WR: begin
            cmd_o.ent_wr     = 1'b1;
            cmd_o.emit_plain = 1'b1;
          end
          REQ_READ, REQ_CLEAR: cmd_o.emit_plain = 1'b0;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan       = 1'b1;
        cmd_o.emit_plain = sts_i.scan_done && !sts_i.hit;
      end
      ST_CNT_RD: cmd_o.cnt_rd = 1'b1;
      ST_CNT_WR: cmd_o.cnt_wr = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sweep, cmd_o.load, cmd_o.scan, cmd_o.ent_wr, cmd_o.cnt_rd,
              cmd_o.cnt_wr}))
    else $error("more than one datapath command at once");
  a_load_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_DISPATCH))
    else $error("accepted transfer not dispatched");
  a_count_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CNT_RD) |=> (state_q == ST_CNT_WR))
    else $error("counter read not followed by write-back");
`endif

endmodule

@@ hdl/flow_byte_accounting_top.sv @@
// Top level of the flow byte accounting block.
//
// Requests enter on item_i and are taken at a rising edge where start is high
// and busy is low. Each request gives exactly one result on result_o, shown
// for one cycle with result_valid_o high; the receiver cannot stall it.
// Entry writes and packets of a family other than IPv4 pass through the dispatch
// state only; counter reads and clears then pass counter read and write-back.
// An IPv4 packet scans its protocol's flow table through the single read port
// of the table memory, one entry per cycle. A source hit ends the scan early;
// otherwise it runs to the end of the table. Any hit then goes on through the
// counter read and write-back states. The result appears in the cycle in which
// busy drops. After reset, a clearing pass invalidates all flow entries and
// zeroes all counters; busy is high meanwhile. Counters are 64 bits and wrap.
module flow_byte_accounting_top #(
  parameter int FLOW_ENTRIES = 64,
  parameter int OWNER_SLOTS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fba_pkg::in_item_t  item_i,
  output fba_pkg::out_item_t result_o,
  output logic               result_valid_o
);
  import fba_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  fba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  fba_datapath #(
    .FLOW_ENTRIES (FLOW_ENTRIES),
    .OWNER_SLOTS  (OWNER_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
